@@ hdl/ism_pkg.sv @@
// Shared types and constants of the interval set merge/insert block.
// Used by every module under hdl but ism_ram; depends on nothing.
`default_nettype none

package ism_pkg;

    localparam int DEF_MAX_INTERVALS = 16;
    localparam int TIME_W            = 64;
    localparam int ACTION_W          = 2;
    localparam int COUNT_W           = 5;
    localparam int ENTRY_W           = 2 * TIME_W;

    localparam logic [TIME_W-1:0] SIGN_BIT = {1'b1, {(TIME_W - 1){1'b0}}};

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_QUERY = 2'd1,
        K_CLEAR = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    // start and end are held as order-preserving unsigned keys
    typedef struct packed {
        t_kind             kind;
        logic [TIME_W-1:0] key_start;
        logic [TIME_W-1:0] key_end;
    } t_cmd;

    typedef struct packed {
        logic               covered;
        logic               dropped_full;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/interval_set_merge_insert.sv @@
// Interval set with merge-on-insert: top level joining front and back ends.
// Depends on ism_pkg, ism_front, ism_back (and ism_ram below it).
//
// Use: items enter through a queue-style port. Drive i_action, i_range_start
// and i_range_end with push; a beat is taken at a clock edge with push high
// and full low. Action 0 adds the range, 1 asks whether one stored interval
// holds both ends, 2 empties the table. One result per item leaves through
// a second queue port: while empty is low the oldest result sits on
// o_covered, o_dropped_full and o_entry_count; pop with empty low takes it.
// Steps: an add runs through taking the command, a walk through the table
// RAM, a decide step, a shift that opens a slot for an insert or closes up
// entries after a merge, and posting its result; a query runs take, walk,
// decide and post, and a clear runs take and post. The table RAM, with one
// registered read and one write per cycle, sets the pace of the walk and the
// shift. The front queue is registered ahead of the take and the result
// shows on the ports the cycle after it is posted.
// Two commands wait in the front queue and two results in the result
// queue; a stalled receiver holds results there and, once both are full,
// the back end pauses and full rises. Synchronous reset empties both
// queues and the table; the table RAM needs no clearing pass.
`default_nettype none

module interval_set_merge_insert #(
    parameter int MAX_INTERVALS = ism_pkg::DEF_MAX_INTERVALS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [ism_pkg::ACTION_W-1:0]      i_action,
    input  wire logic signed [ism_pkg::TIME_W-1:0] i_range_start,
    input  wire logic signed [ism_pkg::TIME_W-1:0] i_range_end,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   o_covered,
    output logic                                   o_dropped_full,
    output logic [ism_pkg::COUNT_W-1:0]            o_entry_count
);
    import ism_pkg::*;

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_take;
    t_result res;

    ism_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_take    (cmd_take)
    );

    ism_back #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .pop         (pop),
        .empty       (empty),
        .o_res       (res)
    );

    assign o_covered      = res.covered;
    assign o_dropped_full = res.dropped_full;
    assign o_entry_count  = res.entry_count;

endmodule

`default_nettype wire

@@ hdl/ism_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module ism_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/ism_front.sv @@
// Front end: accepts input beats, classifies them into commands and
// queues them for the back end. Depends on ism_pkg.
`default_nettype none

module ism_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [ism_pkg::ACTION_W-1:0]  i_action,
    input  wire logic signed [ism_pkg::TIME_W-1:0] i_range_start,
    input  wire logic signed [ism_pkg::TIME_W-1:0] i_range_end,
    output logic                               o_cmd_valid,
    output ism_pkg::t_cmd                      o_cmd,
    input  wire logic                          i_cmd_take
);
    import ism_pkg::*;

    t_cmd              r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    t_cmd              cls;
    logic [TIME_W-1:0] key_s;
    logic [TIME_W-1:0] key_e;
    logic              acc;
    logic              take;

    assign key_s = $unsigned(i_range_start) ^ SIGN_BIT;
    assign key_e = $unsigned(i_range_end) ^ SIGN_BIT;

    always_comb begin
        cls.key_start = key_s;
        cls.key_end   = key_e;
        unique case (i_action)
            ACT_ADD:   cls.kind = (key_e < key_s) ? K_NOP : K_ADD;
            ACT_QUERY: cls.kind = K_QUERY;
            ACT_CLEAR: cls.kind = K_CLEAR;
            default:   cls.kind = K_NOP;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign acc         = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign take        = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
            end
            if (take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(acc) - 2'(take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ism_back.sv @@
// Back end: walks the interval table held in RAM, merges, inserts and
// closes up entries, and queues one result per command. Depends on
// ism_pkg and ism_ram.
`default_nettype none

module ism_back #(
    parameter int MAX_INTERVALS = ism_pkg::DEF_MAX_INTERVALS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cmd_valid,
    input  wire ism_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    input  wire logic      pop,
    output logic           empty,
    output ism_pkg::t_result o_res
);
    import ism_pkg::*;

    localparam int AW  = $clog2(MAX_INTERVALS);
    localparam int CW  = $clog2(MAX_INTERVALS + 1);
    localparam int TW1 = TIME_W + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_UP     = 6'b001000,
        S_DN     = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state            r_state,    n_state;
    t_cmd              r_cmd,      n_cmd;
    logic [CW-1:0]     r_count,    n_count;
    logic [CW-1:0]     r_idx,      n_idx;
    logic [CW-1:0]     r_left,     n_left;
    logic              r_dv,       n_dv;
    logic [AW-1:0]     r_didx;
    logic              r_hit,      n_hit;
    logic              r_pfound,   n_pfound;
    logic [CW-1:0]     r_pos,      n_pos;
    logic [AW-1:0]     r_first,    n_first;
    logic [AW-1:0]     r_last,     n_last;
    logic [TIME_W-1:0] r_first_st, n_first_st;
    logic [TIME_W-1:0] r_last_en,  n_last_en;
    logic [AW-1:0]     r_gone,     n_gone;
    logic              r_cov,      n_cov;
    logic              r_drop,     n_drop;

    t_result           r_rq [2];
    logic              r_rq_wp;
    logic              r_rq_rp;
    logic [1:0]        r_rq_cnt;
    logic              rq_push;
    logic              rq_pop;
    t_result           rq_in;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [TIME_W-1:0]  rd_st;
    logic [TIME_W-1:0]  rd_en;
    logic               beat_touch;
    logic               beat_above;
    logic               beat_cover;

    ism_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_st = ram_rdata[ENTRY_W-1:TIME_W];
    assign rd_en = ram_rdata[TIME_W-1:0];

    assign beat_touch = ({1'b0, rd_st} <= ({1'b0, r_cmd.key_end} + TW1'(1)))
                     && (({1'b0, rd_en} + TW1'(1)) >= {1'b0, r_cmd.key_start});
    assign beat_above = rd_st > r_cmd.key_start;
    assign beat_cover = (rd_st <= r_cmd.key_start) && (r_cmd.key_start <= rd_en)
                     && (rd_st <= r_cmd.key_end) && (r_cmd.key_end <= rd_en);

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && (r_rq_cnt != 2'd2);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_idx      = r_idx;
        n_left     = r_left;
        n_dv       = 1'b0;
        n_hit      = r_hit;
        n_pfound   = r_pfound;
        n_pos      = r_pos;
        n_first    = r_first;
        n_last     = r_last;
        n_first_st = r_first_st;
        n_last_en  = r_last_en;
        n_gone     = r_gone;
        n_cov      = r_cov;
        n_drop     = r_drop;
        ram_we     = 1'b0;
        ram_waddr  = r_didx;
        ram_wdata  = ram_rdata;
        rq_push    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (o_cmd_take) begin
                    n_cmd  = i_cmd;
                    n_cov  = 1'b0;
                    n_drop = 1'b0;
                    unique case (i_cmd.kind)
                        K_CLEAR: begin
                            n_count = '0;
                            n_state = S_FIN;
                        end
                        K_NOP: begin
                            n_state = S_FIN;
                        end
                        K_ADD, K_QUERY: begin
                            n_idx    = '0;
                            n_hit    = 1'b0;
                            n_pfound = 1'b0;
                            n_pos    = r_count;
                            n_state  = S_SCAN;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx != r_count) begin
                    n_dv  = 1'b1;
                    n_idx = r_idx + CW'(1);
                end
                if (r_dv) begin
                    if (beat_touch) begin
                        if (!r_hit) begin
                            n_first    = r_didx;
                            n_first_st = rd_st;
                        end
                        n_hit     = 1'b1;
                        n_last    = r_didx;
                        n_last_en = rd_en;
                    end
                    if (beat_above && !r_pfound) begin
                        n_pfound = 1'b1;
                        n_pos    = CW'(r_didx);
                    end
                    if (beat_cover && (r_cmd.kind == K_QUERY)) begin
                        n_cov = 1'b1;
                    end
                end
                if ((r_idx == r_count) && !r_dv) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_cmd.kind == K_QUERY) begin
                    n_state = S_FIN;
                end else if (!r_hit) begin
                    if (r_count == CW'(MAX_INTERVALS)) begin
                        n_drop  = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_left  = r_count - r_pos;
                        n_idx   = r_count - CW'(1);
                        n_state = S_UP;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_first;
                    ram_wdata = {((r_first_st > r_cmd.key_start) ? r_cmd.key_start
                                                                 : r_first_st),
                                 ((r_last_en > r_cmd.key_end) ? r_last_en
                                                              : r_cmd.key_end)};
                    n_gone    = r_last - r_first;
                    n_count   = r_count - CW'(r_last - r_first);
                    n_left    = r_count - CW'(r_last) - CW'(1);
                    n_idx     = CW'(r_last) + CW'(1);
                    n_state   = S_DN;
                end
            end
            S_UP: begin
                if (r_left != '0) begin
                    n_dv   = 1'b1;
                    n_idx  = r_idx - CW'(1);
                    n_left = r_left - CW'(1);
                end
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_didx + AW'(1);
                end else if (r_left == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[AW-1:0];
                    ram_wdata = {r_cmd.key_start, r_cmd.key_end};
                    n_count   = r_count + CW'(1);
                    n_state   = S_FIN;
                end
            end
            S_DN: begin
                if (r_left != '0) begin
                    n_dv   = 1'b1;
                    n_idx  = r_idx + CW'(1);
                    n_left = r_left - CW'(1);
                end
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_didx - r_gone;
                end else if (r_left == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                rq_push = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign rq_in.covered      = r_cov;
    assign rq_in.dropped_full = r_drop;
    assign rq_in.entry_count  = COUNT_W'(r_count);

    assign empty  = (r_rq_cnt == 2'd0);
    assign rq_pop = pop && !empty;
    assign o_res  = r_rq[r_rq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_rq_wp  <= 1'b0;
            r_rq_rp  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
            if (rq_push) begin
                r_rq_wp <= ~r_rq_wp;
            end
            if (rq_pop) begin
                r_rq_rp <= ~r_rq_rp;
            end
            r_rq_cnt <= r_rq_cnt + 2'(rq_push) - 2'(rq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_didx     <= r_idx[AW-1:0];
        r_hit      <= n_hit;
        r_pfound   <= n_pfound;
        r_pos      <= n_pos;
        r_first    <= n_first;
        r_last     <= n_last;
        r_first_st <= n_first_st;
        r_last_en  <= n_last_en;
        r_gone     <= n_gone;
        r_cov      <= n_cov;
        r_drop     <= n_drop;
        if (rq_push) begin
            r_rq[r_rq_wp] <= rq_in;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_INTERVALS))
        else $error("entry count beyond table depth");

    a_rq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_rq_cnt != 2'd2))
        else $error("result queue overflow");

    a_merge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_hit) |-> (r_first <= r_last))
        else $error("merge run reversed");

    a_beat_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN || r_state == S_UP || r_state == S_DN))
        else $error("read beat outside a table walk");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (r_count < CW'(MAX_INTERVALS)))
        else $error("insert into a full table");

endmodule

`default_nettype wire
